// ===== rtl/fctl_pkg.sv =====
// Package for the floor-casting texel lookup block: screen and texture sizes,
// field widths, register indexes and the queue entry type.
// No dependencies.
package fctl_pkg;

    localparam int SCR_H    = 512;
    localparam int SCR_W    = 1024;
    localparam int TEX_SIZE = 64;      // power of two
    localparam int TEX_LOG  = $clog2(TEX_SIZE);

    localparam int ROW_W    = 9;
    localparam int COL_W    = 10;
    localparam int ADDR_W   = 19;
    localparam int DIST_W   = 24;
    localparam int POS_W    = 25;      // Q9.16 floor point
    localparam int IDX_W    = 12;
    localparam int COLOR_W  = 32;
    localparam int PLAYER_W = 24;
    localparam int WGT_W    = 17;      // Q1.16, up to 1.0
    localparam int FRAC_W   = 16;

    localparam int DIFF_W   = ROW_W + 1;
    localparam int DEN_W    = DIFF_W + DIST_W;
    localparam int REM_W    = DEN_W + FRAC_W + 1;
    localparam int STORE_DEPTH = 1 << IDX_W;

    localparam logic [REM_W-1:0] NUMER = REM_W'(SCR_H) << 32;
    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_W;

    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 56;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y = 2'd1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic                 is_load;
        logic                 pix_ok;
        logic [ADDR_W-1:0]    addr;
        logic [POS_W-1:0]     wall_x;
        logic [POS_W-1:0]     wall_y;
        logic [DEN_W-1:0]     den;
        logic [IDX_W-1:0]     tex_idx;
        logic [COLOR_W-1:0]   tex_val;
    } t_fq;

endpackage

// ===== rtl/fctl_front.sv =====
// Front end: takes stream items, classifies load or pixel, forms the floor
// point at the wall, the divisor and the frame address. Uses fctl_pkg.
module fctl_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [fctl_pkg::S_DATA_W-1:0]    i_s_tdata,
    input  logic                             i_s_tuser,
    input  logic                             i_q_full,
    output logic                             o_q_push,
    output fctl_pkg::t_fq                    o_q_data
);

    logic                          r_v;
    fctl_pkg::t_fq                 r_item;
    fctl_pkg::t_fq                 n_item;

    logic [fctl_pkg::IDX_W-1:0]    w_tidx;
    logic [fctl_pkg::COLOR_W-1:0]  w_tval;
    logic [fctl_pkg::COL_W-1:0]    w_col;
    logic [fctl_pkg::ROW_W-1:0]    w_row;
    logic [1:0]                    w_side;
    logic [7:0]                    w_cx;
    logic [7:0]                    w_cy;
    logic [15:0]                   w_frac;
    logic [fctl_pkg::DIST_W-1:0]   w_dist;
    logic [fctl_pkg::POS_W-1:0]    w_addx;
    logic [fctl_pkg::POS_W-1:0]    w_addy;
    logic [fctl_pkg::DIFF_W-1:0]   w_diff;
    logic [31:0]                   w_addr;
    logic                          w_take;

    assign w_tidx = i_s_tdata[11:0];
    assign w_tval = i_s_tdata[43:12];
    assign w_col  = i_s_tdata[53:44];
    assign w_row  = i_s_tdata[62:54];
    assign w_side = i_s_tdata[64:63];
    assign w_cx   = i_s_tdata[72:65];
    assign w_cy   = i_s_tdata[80:73];
    assign w_frac = i_s_tdata[96:81];
    assign w_dist = i_s_tdata[120:97];

    assign o_s_tready = !r_v || !i_q_full;
    assign w_take     = i_s_tvalid && o_s_tready;
    assign o_q_push   = r_v && !i_q_full;
    assign o_q_data   = r_item;

    always_comb begin
        // east 0, south 1, west 2, north 3
        case (w_side)
            2'd0: begin
                w_addx = fctl_pkg::POS_W'(fctl_pkg::WGT_ONE);
                w_addy = fctl_pkg::POS_W'(w_frac);
            end
            2'd1: begin
                w_addx = fctl_pkg::POS_W'(w_frac);
                w_addy = fctl_pkg::POS_W'(fctl_pkg::WGT_ONE);
            end
            2'd2: begin
                w_addx = '0;
                w_addy = fctl_pkg::POS_W'(w_frac);
            end
            default: begin
                w_addx = fctl_pkg::POS_W'(w_frac);
                w_addy = '0;
            end
        endcase
        w_diff = fctl_pkg::DIFF_W'({w_row, 1'b0} - fctl_pkg::DIFF_W'(fctl_pkg::SCR_H));
        w_addr = 32'(w_row) * 32'(fctl_pkg::SCR_W) + 32'(w_col);

        n_item.is_load = !i_s_tuser;
        n_item.pix_ok  = (32'({w_row, 1'b0}) > 32'(fctl_pkg::SCR_H));
        n_item.addr    = w_addr[fctl_pkg::ADDR_W-1:0];
        n_item.wall_x  = {1'b0, w_cx, 16'd0} + w_addx;
        n_item.wall_y  = {1'b0, w_cy, 16'd0} + w_addy;
        n_item.den     = fctl_pkg::DEN_W'(w_diff) * fctl_pkg::DEN_W'(w_dist);
        n_item.tex_idx = w_tidx;
        n_item.tex_val = w_tval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_take) begin
            r_v <= 1'b1;
        end else if (o_q_push) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/fctl_queue.sv =====
// Short queue between front and back ends.
// Uses fctl_pkg for depth and entry type.
module fctl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fctl_pkg::t_fq  i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_nonempty,
    output fctl_pkg::t_fq  o_data
);

    fctl_pkg::t_fq                r_mem [0:fctl_pkg::QUEUE_DEPTH-1];
    logic [fctl_pkg::QPTR_W-1:0]  r_wp;
    logic [fctl_pkg::QPTR_W-1:0]  r_rp;
    logic [fctl_pkg::QPTR_W:0]    r_cnt;

    assign o_full     = (r_cnt == (fctl_pkg::QPTR_W+1)'(fctl_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_data     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (fctl_pkg::QPTR_W+1)'(i_push) - (fctl_pkg::QPTR_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nonempty)
        else $error("queue underflow");
`endif

endmodule

// ===== rtl/fctl_back.sv =====
// Back end: pipelined restoring divider for the weight, blend, texel index,
// texture store write/read and the output register. Uses fctl_pkg.
module fctl_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_nonempty,
    input  fctl_pkg::t_fq                      i_q_data,
    output logic                               o_q_pop,
    input  logic [fctl_pkg::PLAYER_W-1:0]      i_player_x,
    input  logic [fctl_pkg::PLAYER_W-1:0]      i_player_y,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [fctl_pkg::M_DATA_W-1:0]      o_m_tdata,
    output logic                               o_m_tuser
);

    localparam int NSTEP = fctl_pkg::FRAC_W;
    localparam int PW    = fctl_pkg::WGT_W + fctl_pkg::POS_W;

    logic w_en;

    logic                          r_v   [0:NSTEP];
    fctl_pkg::t_fq                 r_pl  [0:NSTEP];
    logic [fctl_pkg::REM_W-1:0]    r_rem [0:NSTEP];
    logic [NSTEP-1:0]              r_q   [0:NSTEP];
    logic                          r_sat [0:NSTEP];

    logic                          r_m_v;
    fctl_pkg::t_fq                 r_m_pl;
    logic [PW-1:0]                 r_m_wx, r_m_px, r_m_wy, r_m_py;

    logic                          r_a_v;
    logic                          r_a_load;
    logic                          r_a_ok;
    logic [fctl_pkg::ADDR_W-1:0]   r_a_addr;
    logic [fctl_pkg::IDX_W-1:0]    r_a_idx;
    logic [fctl_pkg::COLOR_W-1:0]  r_a_val;

    logic                          r_o_v;
    logic                          r_o_ok;
    logic [fctl_pkg::ADDR_W-1:0]   r_o_addr;
    logic [fctl_pkg::COLOR_W-1:0]  r_rdata;
    logic [fctl_pkg::COLOR_W-1:0]  r_store [0:fctl_pkg::STORE_DEPTH-1];

    logic [fctl_pkg::WGT_W-1:0]    w_wgt;
    logic [fctl_pkg::WGT_W-1:0]    w_iwgt;
    logic [PW:0]                   w_sx, w_sy;
    logic [PW:0]                   w_px, w_py;
    logic [fctl_pkg::IDX_W-1:0]    w_idx;

    // whole back end moves together; output register frees the stream side
    assign w_en    = !r_o_v || i_m_tready;
    assign o_q_pop = w_en && i_q_nonempty;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pl[0]  <= i_q_data;
            r_rem[0] <= fctl_pkg::NUMER;
            r_q[0]   <= '0;
            // weight >= 1.0, also covers a zero divisor
            r_sat[0] <= fctl_pkg::NUMER >= (fctl_pkg::REM_W'(i_q_data.den) << NSTEP);
        end
    end

    for (genvar j = 1; j <= NSTEP; j++) begin : g_div
        localparam int K = NSTEP - j;
        logic [fctl_pkg::REM_W-1:0] w_try;
        assign w_try = fctl_pkg::REM_W'(r_pl[j-1].den) << K;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pl[j]  <= r_pl[j-1];
                r_sat[j] <= r_sat[j-1];
                if (r_rem[j-1] >= w_try) begin
                    r_rem[j] <= r_rem[j-1] - w_try;
                    r_q[j]   <= r_q[j-1] | (NSTEP'(1) << K);
                end else begin
                    r_rem[j] <= r_rem[j-1];
                    r_q[j]   <= r_q[j-1];
                end
            end
        end
    end

    assign w_wgt  = r_sat[NSTEP] ? fctl_pkg::WGT_ONE : fctl_pkg::WGT_W'(r_q[NSTEP]);
    assign w_iwgt = fctl_pkg::WGT_ONE - w_wgt;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_pl <= r_pl[NSTEP];
            r_m_wx <= PW'(w_wgt) * PW'(r_pl[NSTEP].wall_x);
            r_m_wy <= PW'(w_wgt) * PW'(r_pl[NSTEP].wall_y);
            r_m_px <= PW'(w_iwgt) * PW'(i_player_x);
            r_m_py <= PW'(w_iwgt) * PW'(i_player_y);
        end
    end

    assign w_sx = (PW+1)'(r_m_wx) + (PW+1)'(r_m_px);
    assign w_sy = (PW+1)'(r_m_wy) + (PW+1)'(r_m_py);
    assign w_px = w_sx >> fctl_pkg::FRAC_W;
    assign w_py = w_sy >> fctl_pkg::FRAC_W;
    // texel coordinate is the top fraction bits of the blended point
    assign w_idx = fctl_pkg::IDX_W'({w_py[15 -: fctl_pkg::TEX_LOG],
                                     w_px[15 -: fctl_pkg::TEX_LOG]});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_load <= r_m_pl.is_load;
            r_a_ok   <= r_m_pl.pix_ok;
            r_a_addr <= r_m_pl.addr;
            r_a_idx  <= r_m_pl.is_load ? r_m_pl.tex_idx : w_idx;
            r_a_val  <= r_m_pl.tex_val;
            r_o_ok   <= r_a_ok;
            r_o_addr <= r_a_addr;
            r_rdata  <= r_store[r_a_idx];
            if (r_a_v && r_a_load) begin
                r_store[r_a_idx] <= r_a_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NSTEP; i++) r_v[i] <= 1'b0;
            r_m_v <= 1'b0;
            r_a_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= o_q_pop;
            for (int i = 1; i <= NSTEP; i++) r_v[i] <= r_v[i-1];
            r_m_v <= r_v[NSTEP];
            r_a_v <= r_m_v;
            r_o_v <= r_a_v && !r_a_load;
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tuser  = r_o_ok;
    assign o_m_tdata  = {5'd0, r_o_addr, r_o_ok ? r_rdata : '0};

`ifndef NO_ASSERTIONS
    a_blank_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[fctl_pkg::COLOR_W-1:0] == '0))
        else $error("pixel above horizon carries a colour");
    a_sat_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NSTEP] && r_sat[NSTEP]) |-> (w_wgt == fctl_pkg::WGT_ONE))
        else $error("saturated weight not one");
`endif

endmodule

// ===== rtl/floor_cast_texel_lookup_unit.sv =====
// Top level of the floor-casting texel lookup: player registers, front end,
// queue and back end. Uses fctl_pkg, fctl_front, fctl_queue, fctl_back.
//
//  channel  dir  handshake                  payload
//  s        in   i_s_tvalid / o_s_tready    i_s_tdata, i_s_tuser (req_type)
//  m        out  o_m_tvalid / i_m_tready    o_m_tdata, o_m_tuser (pixel_valid)
//  cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per clock sustained while the output is not stalled; a pixel's result
// passes through the queue, the saturation check, the 16-step weight divider
// pipeline, and the multiply, sum and texture store read stages.
// Synchronous active-low reset clears control; the texture store is not cleared.
// A stalled output holds the back end; the queue lets the front keep taking items.
module floor_cast_texel_lookup_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [11:0] texel_index, [43:12] texel_value, [53:44] column, [62:54] row,
    // [64:63] wall_side, [72:65] cell_x, [80:73] cell_y, [96:81] hit_fraction,
    // [120:97] wall_distance, rest zero
    input  logic [fctl_pkg::S_DATA_W-1:0]        i_s_tdata,
    input  logic                                 i_s_tuser,    // [0] req_type
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [31:0] pixel_color, [50:32] pixel_address, rest zero
    output logic [fctl_pkg::M_DATA_W-1:0]        o_m_tdata,
    output logic                                 o_m_tuser,    // [0] pixel_valid
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fctl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fctl_pkg::PLAYER_W-1:0]        i_cfg_data
);

    logic [fctl_pkg::PLAYER_W-1:0] r_player_x;
    logic [fctl_pkg::PLAYER_W-1:0] r_player_y;
    logic          w_q_full;
    logic          w_q_push;
    logic          w_q_pop;
    logic          w_q_nonempty;
    fctl_pkg::t_fq w_q_in;
    fctl_pkg::t_fq w_q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player_x <= '0;
            r_player_y <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fctl_pkg::REG_PLAYER_X: r_player_x <= i_cfg_data;
                fctl_pkg::REG_PLAYER_Y: r_player_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fctl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_in)
    );

    fctl_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_q_push),
        .i_data     (w_q_in),
        .o_full     (w_q_full),
        .i_pop      (w_q_pop),
        .o_nonempty (w_q_nonempty),
        .o_data     (w_q_out)
    );

    fctl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (w_q_nonempty),
        .i_q_data     (w_q_out),
        .o_q_pop      (w_q_pop),
        .i_player_x   (r_player_x),
        .i_player_y   (r_player_y),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser)
    );

endmodule
